[hdl/zobk_pkg.sv]
// shared types, command codes and the microcode program of the zobrist key unit
`timescale 1ns / 1ps

package zobk_pkg;

	// command codes of the input transaction
	typedef enum logic [2:0] {
		CMD_NEW_POS  = 3'd0,
		CMD_FLIP     = 3'd1,
		CMD_MOVE     = 3'd2,
		CMD_TURN     = 3'd3,
		CMD_EP_SET   = 3'd4,
		CMD_EP_CLR   = 3'd5,
		CMD_CASTLE   = 3'd6,
		CMD_GENERATE = 3'd7
	} cmd_t;

	// table word read by a step; the read data is xored into the key in the following step
	typedef enum logic [3:0] {
		RD_NONE,
		RD_FROM,
		RD_TO,
		RD_EP_SWAP,
		RD_EP_OLD,
		RD_EP_NEW,
		RD_TURN,
		RD_KS0,
		RD_QS0,
		RD_KS1,
		RD_QS1
	} rd_sel_t;

	// state update done by a step
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_EP_SET,
		ACT_EP_CLR,
		ACT_RIGHTS,
		ACT_SEED,
		ACT_GEN
	} act_t;

	// sequencing of a step
	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_GEN_LOOP,
		JMP_END
	} jmp_t;

	// one control word
	typedef struct packed {
		rd_sel_t rd;
		act_t    act;
		jmp_t    jmp;
	} ctrl_t;

	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	// program entry points
	localparam pc_t PC_NEW_POS  = 5'd0;
	localparam pc_t PC_FLIP     = 5'd1;
	localparam pc_t PC_MOVE     = 5'd3;
	localparam pc_t PC_TURN     = 5'd6;
	localparam pc_t PC_EP_SET   = 5'd8;
	localparam pc_t PC_EP_CLR   = 5'd11;
	localparam pc_t PC_CASTLE   = 5'd13;
	localparam pc_t PC_GENERATE = 5'd18;

	localparam ctrl_t CTRL_END = '{rd: RD_NONE, act: ACT_NONE, jmp: JMP_END};

	// command to program entry
	function automatic pc_t dispatch(input cmd_t cmd);
		pc_t pc;
		case (cmd)
			CMD_NEW_POS:  pc = PC_NEW_POS;
			CMD_FLIP:     pc = PC_FLIP;
			CMD_MOVE:     pc = PC_MOVE;
			CMD_TURN:     pc = PC_TURN;
			CMD_EP_SET:   pc = PC_EP_SET;
			CMD_EP_CLR:   pc = PC_EP_CLR;
			CMD_CASTLE:   pc = PC_CASTLE;
			default:      pc = PC_GENERATE;
		endcase
		return pc;
	endfunction

	// microcode rom
	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t c;
		case (pc)
			5'd0:  c = '{rd: RD_NONE,    act: ACT_CLEAR,  jmp: JMP_END};
			5'd1:  c = '{rd: RD_FROM,    act: ACT_NONE,   jmp: JMP_NEXT};
			5'd2:  c = CTRL_END;
			5'd3:  c = '{rd: RD_FROM,    act: ACT_NONE,   jmp: JMP_NEXT};
			5'd4:  c = '{rd: RD_TO,      act: ACT_NONE,   jmp: JMP_NEXT};
			5'd5:  c = CTRL_END;
			5'd6:  c = '{rd: RD_TURN,    act: ACT_NONE,   jmp: JMP_NEXT};
			5'd7:  c = CTRL_END;
			5'd8:  c = '{rd: RD_EP_SWAP, act: ACT_NONE,   jmp: JMP_NEXT};
			5'd9:  c = '{rd: RD_EP_NEW,  act: ACT_EP_SET, jmp: JMP_NEXT};
			5'd10: c = CTRL_END;
			5'd11: c = '{rd: RD_EP_OLD,  act: ACT_EP_CLR, jmp: JMP_NEXT};
			5'd12: c = CTRL_END;
			5'd13: c = '{rd: RD_KS0,     act: ACT_NONE,   jmp: JMP_NEXT};
			5'd14: c = '{rd: RD_QS0,     act: ACT_NONE,   jmp: JMP_NEXT};
			5'd15: c = '{rd: RD_KS1,     act: ACT_NONE,   jmp: JMP_NEXT};
			5'd16: c = '{rd: RD_QS1,     act: ACT_RIGHTS, jmp: JMP_NEXT};
			5'd17: c = CTRL_END;
			5'd18: c = '{rd: RD_NONE,    act: ACT_SEED,   jmp: JMP_NEXT};
			5'd19: c = '{rd: RD_NONE,    act: ACT_GEN,    jmp: JMP_GEN_LOOP};
			5'd20: c = CTRL_END;
			default: c = CTRL_END;
		endcase
		return c;
	endfunction

	// one xorshift64 step with shifts 13, 7, 17
	function automatic logic [63:0] xorshift64(input logic [63:0] x);
		logic [63:0] a;
		logic [63:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 7);
		return b ^ (b << 17);
	endfunction

endpackage

[hdl/zobk_seq.sv]
// microcode sequencer: step counter, control rom and jumps
`timescale 1ns / 1ps

module zobk_seq
	import zobk_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  launch,
	input  cmd_t  cmd,
	input  logic  gen_last,
	output ctrl_t ctrl,
	output logic  running,
	output logic  done
);

	pc_t  pc_q;
	logic running_q;
	logic done_q;

	// control word of the current step, a no-op while idle
	always_comb begin
		if (running_q) begin
			ctrl = ucode(pc_q);
		end else begin
			ctrl = '{rd: RD_NONE, act: ACT_NONE, jmp: JMP_NEXT};
		end
	end

	// step counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_NEW_POS;
			running_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= running_q && (ctrl.jmp == JMP_END);
			if (launch) begin
				pc_q      <= dispatch(cmd);
				running_q <= 1'b1;
			end else if (running_q) begin
				case (ctrl.jmp)
					JMP_NEXT:     pc_q <= pc_q + 1'b1;
					JMP_GEN_LOOP: if (gen_last) begin
						pc_q <= pc_q + 1'b1;
					end
					JMP_END:      running_q <= 1'b0;
					default:      running_q <= 1'b0;
				endcase
			end
		end
	end

	assign running = running_q;
	assign done    = done_q;

endmodule

[hdl/incremental_zobrist_key_unit.sv]
// top level of the incremental zobrist key unit: key table, key state and datapath
`timescale 1ns / 1ps
//
// Command-driven unit that keeps a 64-bit zobrist position key.
// A command transaction is taken at a rising edge with start high and busy low;
// its fields are captured and a short microprogram runs on one table read port.
// Each command gives one result: position_key_out, rights_out and ep_active are
// valid while done is high, for exactly one cycle; the receiver cannot stall.
// Each step reads at most one table word; generate writes one table word per cycle.
// A new command may be accepted in the cycle where done is high.
// The seed register is written through cfg_valid / cfg_ready / cfg_data; the user
// must do so only while the unit is idle, and the block itself does not enforce it.
// Generate loads the seed into the xorshift64 state.
// Reset clears the key, castling rights and en passant record and sets the seed
// to 1; the key table holds nothing valid until a generate command fills it.
//
module incremental_zobrist_key_unit
	import zobk_pkg::*;
#(
	parameter int BOARD_SQUARES = 64,
	parameter int PIECE_KINDS   = 6,
	parameter int EP_FILES      = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic        is_white,
	input  logic [2:0]  piece_kind,
	input  logic [5:0]  from_square,
	input  logic [5:0]  to_square,
	input  logic [2:0]  ep_file,
	input  logic [3:0]  new_rights,
	output logic        done,
	output logic [63:0] position_key_out,
	output logic [3:0]  rights_out,
	output logic        ep_active,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data
);

	localparam int EP_BASE     = 2 * PIECE_KINDS * BOARD_SQUARES;
	localparam int KS_BASE     = EP_BASE + EP_FILES;
	localparam int QS_BASE     = KS_BASE + 2;
	localparam int TURN_INDEX  = QS_BASE + 2;
	localparam int TABLE_DEPTH = TURN_INDEX + 1;
	localparam int AW          = $clog2(TABLE_DEPTH);

	ctrl_t       ctrl;
	logic        running;
	logic        launch;
	logic        gen_last;

	// captured command fields
	logic        color_q;
	logic [2:0]  kind_q;
	logic [5:0]  from_q;
	logic [5:0]  to_q;
	logic [2:0]  file_q;
	logic [3:0]  rights_q;

	// architectural state
	logic [63:0] seed_q;
	logic [63:0] rng_q;
	logic [63:0] key_q;
	logic [3:0]  castling_q;
	logic        ep_valid_q;
	logic [2:0]  ep_held_q;
	logic [AW-1:0] gen_addr_q;

	// table and read path
	logic [63:0] key_table [TABLE_DEPTH];
	logic [63:0] rdata_q;
	logic        pend_q;
	logic [AW-1:0] rd_addr;
	logic        rd_hit;
	logic [AW-1:0] piece_base;
	logic        kind_ok;
	logic        file_ok;
	logic        held_ok;
	logic [3:0]  diff;
	logic [63:0] rng_next;

	assign launch    = start && !running;
	assign busy      = running;
	assign cfg_ready = 1'b1;
	assign gen_last  = (gen_addr_q == AW'(TABLE_DEPTH - 1));
	assign rng_next  = xorshift64(rng_q);

	zobk_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (launch),
		.cmd      (cmd_t'(command)),
		.gen_last (gen_last),
		.ctrl     (ctrl),
		.running  (running),
		.done     (done)
	);

	// capture the command transaction
	always_ff @(posedge clk) begin
		if (launch) begin
			color_q  <= is_white;
			kind_q   <= piece_kind;
			from_q   <= from_square;
			to_q     <= to_square;
			file_q   <= ep_file;
			rights_q <= new_rights;
		end
	end

	// table address and xor condition of the current step
	always_comb begin
		piece_base = (AW'(color_q) * AW'(PIECE_KINDS) + AW'(kind_q)) * AW'(BOARD_SQUARES);
		kind_ok    = 32'(kind_q) < PIECE_KINDS;
		file_ok    = 32'(file_q) < EP_FILES;
		held_ok    = ep_valid_q && (32'(ep_held_q) < EP_FILES);
		diff       = castling_q ^ rights_q;
		rd_addr    = AW'(TURN_INDEX);
		rd_hit     = 1'b0;
		case (ctrl.rd)
			RD_FROM: begin
				rd_addr = piece_base + AW'(from_q);
				rd_hit  = kind_ok && (32'(from_q) < BOARD_SQUARES);
			end
			RD_TO: begin
				rd_addr = piece_base + AW'(to_q);
				rd_hit  = kind_ok && (32'(to_q) < BOARD_SQUARES);
			end
			RD_EP_SWAP: begin
				rd_addr = AW'(EP_BASE) + AW'(ep_held_q);
				rd_hit  = file_ok && held_ok;
			end
			RD_EP_OLD: begin
				rd_addr = AW'(EP_BASE) + AW'(ep_held_q);
				rd_hit  = held_ok;
			end
			RD_EP_NEW: begin
				rd_addr = AW'(EP_BASE) + AW'(file_q);
				rd_hit  = file_ok;
			end
			RD_TURN: begin
				rd_addr = AW'(TURN_INDEX);
				rd_hit  = 1'b1;
			end
			RD_KS0: begin
				rd_addr = AW'(KS_BASE);
				rd_hit  = diff[0];
			end
			RD_QS0: begin
				rd_addr = AW'(QS_BASE);
				rd_hit  = diff[1];
			end
			RD_KS1: begin
				rd_addr = AW'(KS_BASE + 1);
				rd_hit  = diff[2];
			end
			RD_QS1: begin
				rd_addr = AW'(QS_BASE + 1);
				rd_hit  = diff[3];
			end
			default: begin
				rd_addr = AW'(TURN_INDEX);
				rd_hit  = 1'b0;
			end
		endcase
	end

	// key table: one write port for generation, one registered read port
	always_ff @(posedge clk) begin
		if (ctrl.act == ACT_GEN) begin
			key_table[gen_addr_q] <= rng_next;
		end
		rdata_q <= key_table[rd_addr];
	end

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd1;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	// key, castling, en passant and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			castling_q <= '0;
			ep_valid_q <= 1'b0;
			ep_held_q  <= '0;
			rng_q      <= 64'd1;
			gen_addr_q <= '0;
			pend_q     <= 1'b0;
		end else begin
			pend_q <= rd_hit;
			// apply the word read in the previous step
			if (ctrl.act == ACT_CLEAR) begin
				key_q <= '0;
			end else if (pend_q) begin
				key_q <= key_q ^ rdata_q;
			end
			case (ctrl.act)
				ACT_CLEAR: begin
					castling_q <= '0;
					ep_valid_q <= 1'b0;
					ep_held_q  <= '0;
				end
				ACT_EP_SET: if (file_ok) begin
					ep_valid_q <= 1'b1;
					ep_held_q  <= file_q;
				end
				ACT_EP_CLR: begin
					ep_valid_q <= 1'b0;
					ep_held_q  <= '0;
				end
				ACT_RIGHTS: castling_q <= rights_q;
				ACT_SEED: begin
					rng_q      <= seed_q;
					gen_addr_q <= '0;
				end
				ACT_GEN: begin
					rng_q      <= rng_next;
					gen_addr_q <= gen_addr_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result fields are the live state, sampled while done is high
	assign position_key_out = key_q;
	assign rights_out       = castling_q;
	assign ep_active        = ep_valid_q;

endmodule

[tb/sv/incremental_zobrist_key_unit_tb.sv]
// testbench of the incremental zobrist key unit: key scoreboard, command driver, result monitor
`timescale 1ns / 1ps

module incremental_zobrist_key_unit_tb
	import zobk_pkg::*;
();

	localparam int BOARD_SQUARES = 64;
	localparam int PIECE_KINDS   = 6;
	localparam int EP_FILES      = 8;
	localparam int EP_BASE       = 2 * PIECE_KINDS * BOARD_SQUARES;
	localparam int KS_BASE       = EP_BASE + EP_FILES;
	localparam int QS_BASE       = KS_BASE + 2;
	localparam int TURN_INDEX    = QS_BASE + 2;
	localparam int TABLE_DEPTH   = TURN_INDEX + 1;
	localparam int LIMIT_CYCLES  = 3000000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS   = 205;

	// one command transaction
	typedef struct {
		cmd_t       command;
		logic       is_white;
		logic [2:0] piece_kind;
		logic [5:0] from_square;
		logic [5:0] to_square;
		logic [2:0] ep_file;
		logic [3:0] new_rights;
	} command_txn_t;

	// key, rights and en passant flag returned by one command
	typedef struct {
		logic [63:0] key;
		logic [3:0]  rights;
		logic        ep;
	} key_result_t;

	// tracks the key state and the queue of awaited results
	class zobrist_scoreboard;
		logic [63:0] seed_reg;
		logic [63:0] gen_state;
		logic [63:0] zobrist_words [TABLE_DEPTH];
		logic [63:0] key_acc;
		logic [3:0]  rights_held;
		logic        ep_recorded;
		logic [2:0]  ep_file_rec;
		key_result_t awaited_keys [$];
		int          errors;

		function new();
			seed_reg    = 64'd1;
			gen_state   = 64'd1;
			key_acc     = '0;
			rights_held = '0;
			ep_recorded = 1'b0;
			ep_file_rec = '0;
			errors      = 0;
			foreach (zobrist_words[i]) zobrist_words[i] = '0;
		endfunction

		function void note_seed(logic [63:0] value);
			seed_reg = value;
		endfunction

		function void toggle_piece(logic color, logic [2:0] kind, logic [5:0] sq);
			int idx;
			if (kind >= PIECE_KINDS || sq >= BOARD_SQUARES) return;
			idx = (int'(color) * PIECE_KINDS + int'(kind)) * BOARD_SQUARES + int'(sq);
			key_acc ^= zobrist_words[idx];
		endfunction

		// advance the key state by one accepted command and queue its result
		function void apply_command(command_txn_t t);
			key_result_t r;
			logic [3:0]  diff;
			logic [63:0] x;
			case (t.command)
				CMD_NEW_POS: begin
					key_acc     = '0;
					rights_held = '0;
					ep_recorded = 1'b0;
					ep_file_rec = '0;
				end
				CMD_FLIP: toggle_piece(t.is_white, t.piece_kind, t.from_square);
				CMD_MOVE: begin
					if (t.piece_kind < PIECE_KINDS) begin
						toggle_piece(t.is_white, t.piece_kind, t.from_square);
						toggle_piece(t.is_white, t.piece_kind, t.to_square);
					end
				end
				CMD_TURN: key_acc ^= zobrist_words[TURN_INDEX];
				CMD_EP_SET: begin
					if (t.ep_file < EP_FILES) begin
						if (ep_recorded && ep_file_rec < EP_FILES)
							key_acc ^= zobrist_words[EP_BASE + int'(ep_file_rec)];
						key_acc ^= zobrist_words[EP_BASE + int'(t.ep_file)];
						ep_file_rec = t.ep_file;
						ep_recorded = 1'b1;
					end
				end
				CMD_EP_CLR: begin
					if (ep_recorded && ep_file_rec < EP_FILES)
						key_acc ^= zobrist_words[EP_BASE + int'(ep_file_rec)];
					ep_recorded = 1'b0;
					ep_file_rec = '0;
				end
				CMD_CASTLE: begin
					// every right that changes toggles its own word
					diff = rights_held ^ t.new_rights;
					if (diff[0]) key_acc ^= zobrist_words[KS_BASE];
					if (diff[1]) key_acc ^= zobrist_words[QS_BASE];
					if (diff[2]) key_acc ^= zobrist_words[KS_BASE + 1];
					if (diff[3]) key_acc ^= zobrist_words[QS_BASE + 1];
					rights_held = t.new_rights;
				end
				default: begin
					// refill the table from the seed, one xorshift step per word
					x = seed_reg;
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						x = x ^ (x << 13);
						x = x ^ (x >> 7);
						x = x ^ (x << 17);
						zobrist_words[i] = x;
					end
					gen_state = x;
				end
			endcase
			r.key    = key_acc;
			r.rights = rights_held;
			r.ep     = ep_recorded;
			awaited_keys.push_back(r);
		endfunction

		// compare one strobed result with the oldest awaited one
		function void compare_key_result(logic [63:0] key, logic [3:0] rights, logic ep);
			key_result_t r;
			if (awaited_keys.size() == 0) begin
				$display("%0t: unexpected result: key %h rights %h ep %b",
					$time, key, rights, ep);
				errors++;
				return;
			end
			r = awaited_keys.pop_front();
			if (key !== r.key) begin
				$display("%0t: position_key_out mismatch: expected %h actual %h",
					$time, r.key, key);
				errors++;
			end
			if (rights !== r.rights) begin
				$display("%0t: rights_out mismatch: expected %h actual %h",
					$time, r.rights, rights);
				errors++;
			end
			if (ep !== r.ep) begin
				$display("%0t: ep_active mismatch: expected %b actual %b",
					$time, r.ep, ep);
				errors++;
			end
		endfunction

		function int pending();
			return awaited_keys.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  command;
	logic        is_white;
	logic [2:0]  piece_kind;
	logic [5:0]  from_square;
	logic [5:0]  to_square;
	logic [2:0]  ep_file;
	logic [3:0]  new_rights;
	logic        done;
	logic [63:0] position_key_out;
	logic [3:0]  rights_out;
	logic        ep_active;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] cfg_data;

	zobrist_scoreboard key_board;
	int                cycle_count = 0;
	int                burst_left;

	incremental_zobrist_key_unit #(
		.BOARD_SQUARES(BOARD_SQUARES),
		.PIECE_KINDS(PIECE_KINDS),
		.EP_FILES(EP_FILES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.is_white(is_white),
		.piece_kind(piece_kind),
		.from_square(from_square),
		.to_square(to_square),
		.ep_file(ep_file),
		.new_rights(new_rights),
		.done(done),
		.position_key_out(position_key_out),
		.rights_out(rights_out),
		.ep_active(ep_active),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// clock
	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			key_board.compare_key_result(position_key_out, rights_out, ep_active);
	end

	function automatic command_txn_t make_command(cmd_t c, logic w, logic [2:0] kind,
			logic [5:0] from_sq, logic [5:0] to_sq, logic [2:0] file, logic [3:0] rights);
		command_txn_t t;
		t.command     = c;
		t.is_white    = w;
		t.piece_kind  = kind;
		t.from_square = from_sq;
		t.to_square   = to_sq;
		t.ep_file     = file;
		t.new_rights  = rights;
		return t;
	endfunction

	// mostly legal piece kinds, weighted toward board updates, generate is rare
	function automatic command_txn_t random_command();
		command_txn_t t;
		int unsigned  pick;
		t.is_white    = 1'($urandom_range(0, 1));
		t.piece_kind  = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, 5))
			: 3'($urandom_range(0, 7));
		t.from_square = 6'($urandom_range(0, 63));
		t.to_square   = ($urandom_range(0, 19) == 0) ? t.from_square
			: 6'($urandom_range(0, 63));
		t.ep_file     = 3'($urandom_range(0, 7));
		t.new_rights  = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 999);
		if (pick < 40)       t.command = CMD_NEW_POS;
		else if (pick < 300) t.command = CMD_FLIP;
		else if (pick < 560) t.command = CMD_MOVE;
		else if (pick < 660) t.command = CMD_TURN;
		else if (pick < 770) t.command = CMD_EP_SET;
		else if (pick < 850) t.command = CMD_EP_CLR;
		else if (pick < 995) t.command = CMD_CASTLE;
		else                 t.command = CMD_GENERATE;
		return t;
	endfunction

	// present one command and hold it until the unit takes it
	task automatic drive_item(command_txn_t t);
		@(negedge clk);
		start       <= 1'b1;
		command     <= t.command;
		is_white    <= t.is_white;
		piece_kind  <= t.piece_kind;
		from_square <= t.from_square;
		to_square   <= t.to_square;
		ep_file     <= t.ep_file;
		new_rights  <= t.new_rights;
		do @(posedge clk); while (busy !== 1'b0);
		key_board.apply_command(t);
	endtask

	task automatic idle_gap(int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// stop sending until every awaited result is in
	task automatic drain();
		idle_gap(1);
		while (key_board.pending() != 0) @(posedge clk);
	endtask

	// sender bursts with random gaps, some long unbroken stretches, some full drains
	task automatic send_paced(command_txn_t t);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
				: $urandom_range(1, 24);
			if ($urandom_range(0, 29) == 0)
				drain();
			else if ($urandom_range(0, 3) != 0)
				idle_gap($urandom_range(1, 8));
		end
		burst_left--;
		drive_item(t);
	endtask

	// seed write, only with the unit idle
	task automatic write_seed(logic [63:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		key_board.note_seed(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		command_txn_t opening [$];
		logic [63:0]  phase_seed;

		key_board   = new();
		burst_left  = 0;
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		command     = CMD_NEW_POS;
		is_white    = 1'b0;
		piece_kind  = '0;
		from_square = '0;
		to_square   = '0;
		ep_file     = '0;
		new_rights  = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: table built from the reset seed before any table read
		opening.push_back(make_command(CMD_NEW_POS, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(CMD_GENERATE, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(CMD_FLIP, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(CMD_FLIP, 1, 5, 63, 0, 7, 15));
		// invalid piece kinds leave the key alone
		opening.push_back(make_command(CMD_FLIP, 1, 6, 10, 0, 0, 0));
		opening.push_back(make_command(CMD_MOVE, 0, 1, 1, 18, 0, 0));
		opening.push_back(make_command(CMD_MOVE, 1, 4, 63, 0, 0, 0));
		// same square move cancels out
		opening.push_back(make_command(CMD_MOVE, 0, 3, 20, 20, 0, 0));
		opening.push_back(make_command(CMD_MOVE, 1, 7, 5, 6, 0, 0));
		opening.push_back(make_command(CMD_TURN, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(CMD_EP_SET, 0, 0, 0, 0, 0, 0));
		// set over a recorded file swaps it out
		opening.push_back(make_command(CMD_EP_SET, 0, 0, 0, 0, 7, 0));
		opening.push_back(make_command(CMD_EP_CLR, 0, 0, 0, 0, 0, 0));
		// clear with nothing recorded
		opening.push_back(make_command(CMD_EP_CLR, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(CMD_CASTLE, 0, 0, 0, 0, 0, 15));
		opening.push_back(make_command(CMD_CASTLE, 0, 0, 0, 0, 0, 5));
		opening.push_back(make_command(CMD_CASTLE, 0, 0, 0, 0, 0, 10));
		opening.push_back(make_command(CMD_CASTLE, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(CMD_TURN, 1, 7, 63, 63, 7, 15));
		opening.push_back(make_command(CMD_EP_SET, 0, 0, 0, 0, 3, 0));
		opening.push_back(make_command(CMD_CASTLE, 0, 0, 0, 0, 0, 9));
		opening.push_back(make_command(CMD_NEW_POS, 1, 7, 63, 63, 7, 15));
		foreach (opening[i]) send_paced(opening[i]);

		// zero seed gives an all zero table
		write_seed(64'd0);
		send_paced(make_command(CMD_GENERATE, 0, 0, 0, 0, 0, 0));
		send_paced(make_command(CMD_FLIP, 0, 2, 33, 0, 0, 0));
		send_paced(make_command(CMD_CASTLE, 0, 0, 0, 0, 0, 15));

		// random phases, each with its own seed and a fresh table
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       phase_seed = 64'hFFFF_FFFF_FFFF_FFFF;
				2:       phase_seed = 64'd1;
				default: phase_seed = {$urandom, $urandom};
			endcase
			write_seed(phase_seed);
			send_paced(make_command(CMD_GENERATE, 0, 0, 0, 0, 0, 0));
			repeat (PHASE_ITEMS) send_paced(random_command());
		end

		drain();
		repeat (20) @(posedge clk);
		if (key_board.errors == 0 && key_board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
